// ===== rtl/core/qsl_pkg.sv =====
// types, constants and helper functions shared by the quoted string lexer
// no dependencies

package qsl_pkg;

    localparam int CHAR_W  = 8;
    localparam int QBYTES  = 4;
    localparam int CNT_W   = 3;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_OPEN_BYTES  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OPEN_LEN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_BYTES = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_LEN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE      = 3'd4;

    localparam logic [31:0]       RST_OPEN_BYTES  = 32'd34;
    localparam logic [CNT_W-1:0]  RST_OPEN_LEN    = 3'd1;
    localparam logic [31:0]       RST_CLOSE_BYTES = 32'd34;
    localparam logic [CNT_W-1:0]  RST_CLOSE_LEN   = 3'd1;
    localparam logic [CHAR_W-1:0] RST_ESCAPE      = 8'd92;

    localparam logic [CHAR_W-1:0] CH_N   = 8'h6e;
    localparam logic [CHAR_W-1:0] CH_R   = 8'h72;
    localparam logic [CHAR_W-1:0] CH_B   = 8'h62;
    localparam logic [CHAR_W-1:0] CH_T   = 8'h74;
    localparam logic [CHAR_W-1:0] CH_A   = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LF  = 8'h0a;
    localparam logic [CHAR_W-1:0] CH_CR  = 8'h0d;
    localparam logic [CHAR_W-1:0] CH_BS  = 8'h08;
    localparam logic [CHAR_W-1:0] CH_HT  = 8'h09;
    localparam logic [CHAR_W-1:0] CH_BEL = 8'h07;

    typedef struct packed {
        logic              restart;
        logic              is_esc;
        logic [CHAR_W-1:0] ch;
        logic [CHAR_W-1:0] xlat;
    } t_item;

    typedef struct packed {
        logic              accepted;
        logic              content_valid;
        logic [CHAR_W-1:0] content_char;
        logic              closed;
    } t_result;

    typedef struct packed {
        logic [31:0]      open_bytes;
        logic [CNT_W-1:0] open_len;
        logic [31:0]      close_bytes;
        logic [CNT_W-1:0] close_len;
    } t_quote_cfg;

    function automatic logic [CHAR_W-1:0] translate(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] r;
        case (c)
            CH_N:    r = CH_LF;
            CH_R:    r = CH_CR;
            CH_B:    r = CH_BS;
            CH_T:    r = CH_HT;
            CH_A:    r = CH_BEL;
            default: r = c;
        endcase
        return r;
    endfunction

    // index beyond the packed word reads as zero
    function automatic logic [CHAR_W-1:0] quote_byte(input logic [31:0] p,
                                                     input logic [CNT_W-1:0] idx);
        logic [CHAR_W-1:0] r;
        if (idx[2]) begin
            r = '0;
        end else begin
            r = p[{idx[1:0], 3'b000} +: CHAR_W];
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/qsl_front.sv =====
// front end: classifies each incoming character and pushes it into the queue
// depends on qsl_pkg

module qsl_front (
    input  logic                      i_valid,
    input  logic                      i_restart,
    input  logic [qsl_pkg::CHAR_W-1:0] i_char_in,
    input  logic [qsl_pkg::CHAR_W-1:0] i_escape_char,
    input  logic                      i_q_full,
    output logic                      o_stall,
    output logic                      o_push,
    output qsl_pkg::t_item            o_item
);

    assign o_stall = i_q_full;
    assign o_push  = i_valid && !i_q_full;

    always_comb begin
        o_item.restart = i_restart;
        o_item.is_esc  = (i_escape_char != '0) && (i_char_in == i_escape_char);
        o_item.ch      = i_char_in;
        o_item.xlat    = qsl_pkg::translate(i_char_in);
    end

endmodule

// ===== rtl/core/qsl_queue.sv =====
// two-word queue between front and back ends
// depends on qsl_pkg

module qsl_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  qsl_pkg::t_item i_item,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output qsl_pkg::t_item o_item
);

    qsl_pkg::t_item r_mem [2];
    logic           r_wptr, n_wptr;
    logic           r_rptr, n_rptr;
    logic [1:0]     r_cnt, n_cnt;

    assign o_full  = r_cnt[1];
    assign o_valid = r_cnt != 2'd0;
    assign o_item  = r_mem[r_rptr];

    always_comb begin
        n_wptr = i_push ? !r_wptr : r_wptr;
        n_rptr = i_pop  ? !r_rptr : r_rptr;
        n_cnt  = r_cnt + {1'b0, i_push} - {1'b0, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

endmodule

// ===== rtl/core/qsl_back.sv =====
// back end: quote matching state, escape handling and the output register
// depends on qsl_pkg

module qsl_back #(
    parameter int QUOTE_MAX_LEN = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  qsl_pkg::t_quote_cfg i_cfg,
    input  logic               i_q_valid,
    input  qsl_pkg::t_item     i_item,
    output logic               o_pop,
    input  logic               i_stall,
    output logic               o_valid,
    output qsl_pkg::t_result   o_result
);

    localparam logic [qsl_pkg::CNT_W:0] MAX_LEN = (qsl_pkg::CNT_W+1)'(QUOTE_MAX_LEN);

    logic [qsl_pkg::CNT_W-1:0] r_om, n_om;
    logic [qsl_pkg::CNT_W-1:0] r_cm, n_cm;
    logic                      r_ep, n_ep;
    logic                      r_out_vld;
    qsl_pkg::t_result          r_out, n_out;

    logic [qsl_pkg::CNT_W-1:0] olen, clen, om, cm;
    logic                      ep, open_done;

    assign o_pop    = i_q_valid && (!r_out_vld || !i_stall);
    assign o_valid  = r_out_vld;
    assign o_result = r_out;

    always_comb begin
        olen = ({1'b0, i_cfg.open_len} > MAX_LEN) ? MAX_LEN[qsl_pkg::CNT_W-1:0]
                                                  : i_cfg.open_len;
        clen = ({1'b0, i_cfg.close_len} > MAX_LEN) ? MAX_LEN[qsl_pkg::CNT_W-1:0]
                                                   : i_cfg.close_len;
        om = i_item.restart ? '0 : r_om;
        cm = i_item.restart ? '0 : r_cm;
        ep = i_item.restart ? 1'b0 : r_ep;
        open_done = (om == olen);

        n_om = om;
        n_cm = cm;
        n_ep = ep;
        n_out.accepted      = 1'b0;
        n_out.content_valid = 1'b0;
        n_out.content_char  = '0;

        if (i_item.is_esc && !ep) begin
            if (open_done && cm == '0) begin
                n_ep = 1'b1;
                n_out.accepted = 1'b1;
            end
        end else if (!open_done) begin
            if (om < olen && i_item.ch == qsl_pkg::quote_byte(i_cfg.open_bytes, om)) begin
                n_om = om + 1'b1;
                n_out.accepted = 1'b1;
            end
        end else if (cm != clen) begin
            n_out.accepted = 1'b1;
            if (ep) begin
                n_out.content_valid = 1'b1;
                n_out.content_char  = i_item.xlat;
                n_ep = 1'b0;
            end else if (cm < clen &&
                         i_item.ch == qsl_pkg::quote_byte(i_cfg.close_bytes, cm)) begin
                n_cm = cm + 1'b1;
            end else begin
                n_out.content_valid = 1'b1;
                n_out.content_char  = i_item.ch;
            end
        end

        n_out.closed = (n_om == olen) && (n_cm == clen);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_om      <= '0;
            r_cm      <= '0;
            r_ep      <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_pop) begin
                r_om <= n_om;
                r_cm <= n_cm;
                r_ep <= n_ep;
            end
            if (o_pop) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= n_out;
        end
    end

    a_pop_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_out_vld)
        else $error("popped word did not reach output register");

    a_emit_accepted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out.content_valid |-> r_out.accepted)
        else $error("content emitted for rejected character");

    a_char_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !r_out.content_valid |-> r_out.content_char == '0)
        else $error("content char not cleared");

    a_no_pop_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && i_stall |-> !o_pop)
        else $error("output overwritten while stalled");

endmodule

// ===== rtl/core/quoted_string_lexer.sv =====
// top level of the quoted string lexer: configuration registers and wiring
// depends on qsl_pkg, qsl_front, qsl_queue, qsl_back

// Takes one character per word and returns one result word per character, at a
// sustained rate of one word per clock while i_stall is low. Each word passes from
// input accept through the two-word queue and then the output register to result
// valid; the back end's update of its match counters and escape flag sets the rate.
// Configuration writes are always ready and must be made only while idle.
module quoted_string_lexer #(
    parameter int QUOTE_MAX_LEN = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_restart,
    input  logic [qsl_pkg::CHAR_W-1:0]    i_char_in,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_accepted,
    output logic                          o_content_valid,
    output logic [qsl_pkg::CHAR_W-1:0]    o_content_char,
    output logic                          o_closed,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [qsl_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                   i_cfg_data
);

    qsl_pkg::t_quote_cfg        r_qcfg;
    logic [qsl_pkg::CHAR_W-1:0] r_escape;

    logic             q_full, q_push, q_valid, q_pop;
    qsl_pkg::t_item   f_item, q_item;
    qsl_pkg::t_result res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qcfg.open_bytes  <= qsl_pkg::RST_OPEN_BYTES;
            r_qcfg.open_len    <= qsl_pkg::RST_OPEN_LEN;
            r_qcfg.close_bytes <= qsl_pkg::RST_CLOSE_BYTES;
            r_qcfg.close_len   <= qsl_pkg::RST_CLOSE_LEN;
            r_escape           <= qsl_pkg::RST_ESCAPE;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                qsl_pkg::CFG_OPEN_BYTES:  r_qcfg.open_bytes  <= i_cfg_data;
                qsl_pkg::CFG_OPEN_LEN:    r_qcfg.open_len    <= i_cfg_data[2:0];
                qsl_pkg::CFG_CLOSE_BYTES: r_qcfg.close_bytes <= i_cfg_data;
                qsl_pkg::CFG_CLOSE_LEN:   r_qcfg.close_len   <= i_cfg_data[2:0];
                qsl_pkg::CFG_ESCAPE:      r_escape           <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    qsl_front u_front (
        .i_valid       (i_valid),
        .i_restart     (i_restart),
        .i_char_in     (i_char_in),
        .i_escape_char (r_escape),
        .i_q_full      (q_full),
        .o_stall       (o_stall),
        .o_push        (q_push),
        .o_item        (f_item)
    );

    qsl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (f_item),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    qsl_back #(
        .QUOTE_MAX_LEN (QUOTE_MAX_LEN)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_qcfg),
        .i_q_valid (q_valid),
        .i_item    (q_item),
        .o_pop     (q_pop),
        .i_stall   (i_stall),
        .o_valid   (o_valid),
        .o_result  (res)
    );

    assign o_accepted      = res.accepted;
    assign o_content_valid = res.content_valid;
    assign o_content_char  = res.content_char;
    assign o_closed        = res.closed;

endmodule
